// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is held
`define SID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, skipped while reset is held
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/sid_pkg.sv
// constants, types and helpers of the silence interval detector
`default_nettype none

package sid_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int SAMPLE_W    = 32;
    localparam int THR_W       = 32;
    localparam int LEN_W       = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CMP_W       = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx IDX_MAX = t_idx'(MAX_SAMPLES - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = '0;
    localparam logic [LEN_W-1:0] MIN_LEN_RST   = LEN_W'(2);

    // exact magnitude, the most negative value gives 2^31
    function automatic logic [SAMPLE_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] u;
        u = s;
        return u[SAMPLE_W-1] ? (SAMPLE_W'(0) - u) : u;
    endfunction

    // low bits of an index, zero extended where the index is narrower
    function automatic logic [OUT_W-1:0] to_out(input t_idx v);
        logic [IDX_W+OUT_W-1:0] wide;
        wide = {{OUT_W{1'b0}}, v};
        return wide[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/silence_interval_detector_core.sv
// silence interval detector: input register, state update, result register
// an accepted item passes the input register and the state update, and its result is offered from the result register
// throughput: one item per cycle, set by the state update, while the result slot is not full and stalled
// the result register keeps taking items while the output side is not stalled
// synchronous active-low reset clears the index, run state and valid flags,
// and returns threshold to 0 and minimum silence length to 2
`default_nettype none

module silence_interval_detector_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sid_pkg::THR_W-1:0]         i_cfg_data,
    // sample items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [sid_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                              i_last,
    // interval items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [sid_pkg::OUT_W-1:0]              o_interval_start,
    output logic [sid_pkg::OUT_W-1:0]              o_interval_end
);

    // configuration registers
    logic [sid_pkg::THR_W-1:0] r_threshold;
    logic [sid_pkg::LEN_W-1:0] r_min_len;

    // input stage: magnitude is worked out on the way in
    logic                         r_in_valid;
    logic [sid_pkg::SAMPLE_W-1:0] r_mag;
    logic                         r_last;

    // detector state
    sid_pkg::t_idx r_idx,   n_idx;
    sid_pkg::t_idx r_start, n_start;
    logic          r_run,   n_run;
    logic          r_conf,  n_conf;

    // result register
    logic                      r_out_valid;
    logic [sid_pkg::OUT_W-1:0] r_out_start;
    logic [sid_pkg::OUT_W-1:0] r_out_end;

    logic                      out_free;
    logic                      advance;
    logic                      quiet;
    logic                      emit;
    sid_pkg::t_idx             res_start;
    sid_pkg::t_idx             res_end;
    logic [sid_pkg::CMP_W-1:0] run_len;

    // config is always taken; the user must write it only while idle, the block itself does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= sid_pkg::THRESHOLD_RST;
            r_min_len   <= sid_pkg::MIN_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sid_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                sid_pkg::REG_MIN_LEN:   r_min_len   <= i_cfg_data[sid_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the held item moves on whenever the result slot is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_mag  <= sid_pkg::magnitude(i_sample);
            r_last <= i_last;
        end
    end

    // state update for the held item
    always_comb begin
        quiet     = r_mag < r_threshold;
        n_idx     = r_idx;
        n_start   = r_start;
        n_run     = r_run;
        n_conf    = r_conf;
        emit      = 1'b0;
        res_start = r_start;
        res_end   = r_start;
        run_len   = '0;

        if (quiet) begin
            // a fresh run starts at this sample
            if (!r_run) begin
                n_start = r_idx;
            end
            n_run   = 1'b1;
            run_len = sid_pkg::CMP_W'(r_idx - n_start) + sid_pkg::CMP_W'(1);
            if (run_len >= sid_pkg::CMP_W'(r_min_len)) begin
                n_conf = 1'b1;
            end
        end else begin
            // loud sample closes a confirmed silence at the previous index,
            // clamped to the start where saturation held the index still
            if (r_conf) begin
                emit      = 1'b1;
                res_start = r_start;
                res_end   = (r_idx > r_start) ? (r_idx - sid_pkg::t_idx'(1)) : r_start;
            end
            n_conf = 1'b0;
            n_run  = 1'b0;
        end

        if (r_last) begin
            // last sample inside a confirmed silence closes it here
            if (n_conf && !emit) begin
                emit      = 1'b1;
                res_start = n_start;
                res_end   = r_idx;
            end
            n_idx   = '0;
            n_start = '0;
            n_run   = 1'b0;
            n_conf  = 1'b0;
        end else if (r_idx < sid_pkg::IDX_MAX) begin
            n_idx = r_idx + sid_pkg::t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_start <= '0;
            r_run   <= 1'b0;
            r_conf  <= 1'b0;
        end else if (advance) begin
            r_idx   <= n_idx;
            r_start <= n_start;
            r_run   <= n_run;
            r_conf  <= n_conf;
        end
    end

    // result register, reloaded whenever the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_start <= sid_pkg::to_out(res_start);
            r_out_end   <= sid_pkg::to_out(res_end);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_interval_start = r_out_start;
    assign o_interval_end   = r_out_end;

endmodule

`default_nettype wire

// File: src/sid_checker.sv
// port-level checker of the silence interval detector and its bind
`default_nettype none

`include "assert_macros.svh"

module sid_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_stall,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [sid_pkg::OUT_W-1:0]         i_interval_start,
    input wire logic [sid_pkg::OUT_W-1:0]         i_interval_end
);

    logic [2*sid_pkg::OUT_W-1:0] payload;

    assign payload = {i_interval_start, i_interval_end};

    // a stalled interval stays offered
    `SID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)

    // input back-pressure only comes from a full, stalled result slot
    `SID_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, i_in_stall, i_out_valid && i_out_stall)

    // a silence never ends before it starts
    `SID_ASSERT_NOW(a_order, i_clk, i_rst_n, i_out_valid, i_interval_end >= i_interval_start)

    // a stalled interval keeps its indices
    `SID_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(payload))

endmodule

bind silence_interval_detector_core sid_checker u_sid_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_interval_start (o_interval_start),
    .i_interval_end   (o_interval_end)
);

`default_nettype wire
